// ----- hw/rtl/sensor_value_to_ascii_decimal_core_defines.svh -----
// Assertion macros for the number-to-ASCII formatter.
// Included by files that check their own logic; no other dependencies.
`ifndef SENSOR_VALUE_TO_ASCII_DECIMAL_CORE_DEFINES_SVH
`define SENSOR_VALUE_TO_ASCII_DECIMAL_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clock, off during reset
`define SVAD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("svad: same-cycle check failed");
// next-cycle implication
`define SVAD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("svad: next-cycle check failed");
`else
`define SVAD_ASSERT_NOW(label, ante, cons)
`define SVAD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/svad_pkg.sv -----
// Shared types and constants of the number-to-ASCII formatter.
// No dependencies; used by every module of the block.
package svad_pkg;

   localparam int MAX_DIGITS = 10;   // cap on decimal-mode zero padding
   localparam int MAX_CHARS  = 12;   // longest text of one number
   localparam int BCD_DIGITS = 10;   // 2^32 has ten decimal digits
   localparam int VALUE_W    = 33;
   localparam int MODE_W     = 3;
   localparam int MIND_W     = 4;
   localparam int POS_W      = 4;
   localparam int SMALL_W    = 14;   // clamped sensor values

   localparam logic [MODE_W-1:0] MODE_DEC   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FIX   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TEMP  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_HUM   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PRESS = 3'd4;

   localparam logic [SMALL_W-1:0] TEMP_LO_MAG = 14'd5000;
   localparam logic [SMALL_W-1:0] TEMP_HI     = 14'd12000;
   localparam logic [SMALL_W-1:0] HUM_HI      = 14'd10000;
   localparam logic [SMALL_W-1:0] ROUND_X10   = 14'd5;
   localparam logic [VALUE_W-1:0] PRESS_HALF  = 33'd128;
   localparam int                 PRESS_FRAC  = 8;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIZE,
      ST_SIGN,
      ST_DIGIT,
      ST_DOT
   } state_type;

   // how to print the converted magnitude
   typedef struct packed {
      logic             ok;      // mode is defined
      logic             neg;     // leading minus
      logic             skip;    // drop lowest BCD digit (divide by ten)
      logic [1:0]       frac;    // digits after the point
      logic [POS_W-1:0] mintot;  // minimum digit count, point excluded
   } fmt_type;

   typedef logic [BCD_DIGITS-1:0][3:0] bcd_type;

endpackage

// ----- hw/rtl/svad_prep.sv -----
// Front end: turns a request into an unsigned magnitude and a print format.
// Depends on svad_pkg.
module svad_prep
   import svad_pkg::*;
#(
   parameter int MAX_DIGITS = svad_pkg::MAX_DIGITS   // cap on decimal-mode zero padding
)
(
   input  logic [MODE_W-1:0]  mode,
   input  logic [VALUE_W-1:0] value,
   input  logic [MIND_W-1:0]  min_digits,
   output logic [VALUE_W-1:0] mag,
   output fmt_type            fmt
);

   logic               vneg;
   logic [VALUE_W-1:0] absv;
   logic               abs_big;
   logic [SMALL_W-1:0] lim;
   logic [SMALL_W-1:0] clamped;
   logic [SMALL_W-1:0] rounded;
   logic [VALUE_W-1:0] press;
   logic [4:0]         dec_lim;
   logic [4:0]         dec_min;

   always_comb begin
      vneg    = value[VALUE_W-1];
      absv    = vneg ? (~value + 33'd1) : value;
      abs_big = |absv[VALUE_W-1:SMALL_W];

      // shared clamp for temperature and humidity, then +5 for rounding
      if (mode == MODE_TEMP) begin
         lim = vneg ? TEMP_LO_MAG : TEMP_HI;
      end else begin
         lim = HUM_HI;
      end
      if (mode == MODE_HUM && vneg) begin
         clamped = '0;
      end else if (abs_big || absv[SMALL_W-1:0] > lim) begin
         clamped = lim;
      end else begin
         clamped = absv[SMALL_W-1:0];
      end
      rounded = clamped + ROUND_X10;

      // Q24.8 round half up; 33-bit sum cannot wrap
      press = ({1'b0, value[31:0]} + PRESS_HALF) >> PRESS_FRAC;

      // decimal padding limit: MAX_DIGITS and room for the sign
      dec_lim = (5'(MAX_DIGITS) < 5'(MAX_CHARS) - {4'd0, vneg}) ?
                5'(MAX_DIGITS) : 5'(MAX_CHARS) - {4'd0, vneg};
      dec_min = ({1'b0, min_digits} > dec_lim) ? dec_lim : {1'b0, min_digits};
      if (dec_min == 5'd0) begin
         dec_min = 5'd1;
      end

      mag        = absv;
      fmt.ok     = 1'b1;
      fmt.neg    = 1'b0;
      fmt.skip   = 1'b0;
      fmt.frac   = 2'd0;
      fmt.mintot = 4'd1;
      case (mode)
         MODE_DEC: begin
            fmt.neg    = vneg;
            fmt.mintot = dec_min[POS_W-1:0];
         end
         MODE_FIX: begin
            fmt.neg    = vneg;
            fmt.frac   = 2'd2;
            fmt.mintot = 4'd3;
         end
         MODE_TEMP: begin
            mag        = {{(VALUE_W-SMALL_W){1'b0}}, rounded};
            fmt.neg    = vneg && (absv >= 33'd5);
            fmt.skip   = 1'b1;
            fmt.frac   = 2'd1;
            fmt.mintot = 4'd2;
         end
         MODE_HUM: begin
            mag        = {{(VALUE_W-SMALL_W){1'b0}}, rounded};
            fmt.skip   = 1'b1;
            fmt.frac   = 2'd1;
            fmt.mintot = 4'd3;
         end
         MODE_PRESS: begin
            mag        = press;
            fmt.mintot = 4'd5;
         end
         default: begin
            fmt.ok = 1'b0;
         end
      endcase
   end

endmodule

// ----- hw/rtl/svad_dabble.sv -----
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on svad_pkg.
module svad_dabble
   import svad_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] din,
   output logic               busy,
   output bcd_type            digits
);

   localparam int CNT_W = $clog2(VALUE_W + 1);

   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [VALUE_W-1:0]        sh_ff, sh_in;
   bcd_type                   bcd_ff, bcd_in;
   bcd_type                   adj;
   logic [BCD_DIGITS*4-1:0]   adj_flat;

   assign busy   = (cnt_ff != '0);
   assign digits = bcd_ff;

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
      adj_flat = adj;

      cnt_in = cnt_ff;
      sh_in  = sh_ff;
      bcd_in = bcd_ff;
      if (start) begin
         cnt_in = CNT_W'(VALUE_W);
         sh_in  = din;
         bcd_in = '0;
      end else if (busy) begin
         cnt_in = cnt_ff - 1'b1;
         sh_in  = {sh_ff[VALUE_W-2:0], 1'b0};
         bcd_in = {adj_flat[BCD_DIGITS*4-2:0], sh_ff[VALUE_W-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      sh_ff  <= sh_in;
      bcd_ff <= bcd_in;
   end

endmodule

// ----- hw/rtl/sensor_value_to_ascii_decimal_core.sv -----
// Top level of the number-to-ASCII decimal formatter: sequencer and output register.
// Depends on svad_pkg, svad_prep, svad_dabble and the assertion macro header.
//
//  channel | direction | ports                              | contents
//  --------+-----------+------------------------------------+--------------------------------
//  req     | in        | req_tvalid/tready/tdata/tuser      | number, min digits, format mode
//  rsp     | out       | rsp_tvalid/tready/tdata/tlast      | ASCII text, tlast on last char
//
// Sequence: an accepted request waits in the converter state while all 33 bits shift in,
//   passes through a sizing state, then sends its text one character at a time (up to 12).
//   req_tready returns once the last character is loaded into the output register, so a
//   new request is taken only after the previous text has left the sequencer.
// req_tready is high only while the sequencer is idle; undefined modes (5..7) are
//   taken and dropped without a result, ready again the next cycle.
// Reset is synchronous and clears the sequencer and rsp_tvalid.
// A low rsp_tready holds the current character and pauses the sequencer.
`include "sensor_value_to_ascii_decimal_core_defines.svh"

module sensor_value_to_ascii_decimal_core
   import svad_pkg::*;
#(
   parameter int MAX_DIGITS = svad_pkg::MAX_DIGITS   // cap on decimal-mode zero padding
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [32:0] value, [36:33] min_digits, [39:37] zero
   input  logic [2:0]  req_tuser,   // [2:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] text_char
   output logic        rsp_tlast    // last_char
);

   state_type          state_ff, state_in;
   fmt_type            fmt_ff, fmt_in;
   fmt_type            fmt_req;
   logic [VALUE_W-1:0] mag_req;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]         rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               req_accept;
   logic               conv_start;
   logic               conv_busy;
   bcd_type            digits;
   logic               out_free;
   logic               emit;
   logic [POS_W-1:0]   sel;
   logic [3:0]         cur_digit;
   logic [POS_W-1:0]   nsig;
   logic [POS_W-1:0]   k;
   logic [POS_W-1:0]   text_len;

   svad_prep #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_prep (
      .mode       (req_tuser),
      .value      (req_tdata[VALUE_W-1:0]),
      .min_digits (req_tdata[VALUE_W+MIND_W-1:VALUE_W]),
      .mag        (mag_req),
      .fmt        (fmt_req)
   );

   svad_dabble u_dabble (
      .clock  (clock),
      .reset  (reset),
      .start  (conv_start),
      .din    (mag_req),
      .busy   (conv_busy),
      .digits (digits)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign conv_start = req_accept && fmt_req.ok;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

   // digit printed at pos_ff; the dropped rounding digit is skipped
   always_comb begin
      sel       = pos_ff + {{(POS_W-1){1'b0}}, fmt_ff.skip};
      cur_digit = (sel < POS_W'(BCD_DIGITS)) ? digits[sel] : 4'd0;
   end

   // significant digits after the skip, at least one
   always_comb begin
      nsig = 4'd1;
      k    = '0;
      for (int j = 0; j < BCD_DIGITS; j++) begin
         k = POS_W'(j) + {{(POS_W-1){1'b0}}, fmt_ff.skip};
         if (k < POS_W'(BCD_DIGITS)) begin
            if (digits[k] != 4'd0) begin
               nsig = POS_W'(j + 1);
            end
         end
      end
      text_len = (nsig > fmt_ff.mintot) ? nsig : fmt_ff.mintot;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (conv_start) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (!conv_busy) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            state_in = fmt_ff.neg ? ST_SIGN : ST_DIGIT;
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               if (pos_ff == '0) begin
                  state_in = ST_IDLE;
               end else if (fmt_ff.frac != 2'd0 &&
                            pos_ff == {{(POS_W-2){1'b0}}, fmt_ff.frac}) begin
                  state_in = ST_DOT;
               end
            end
         end
         ST_DOT: begin
            if (out_free) begin
               state_in = ST_DIGIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath loads
   always_comb begin
      fmt_in      = fmt_ff;
      pos_in      = pos_ff;
      emit        = 1'b0;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      if (req_accept) begin
         fmt_in = fmt_req;
      end
      case (state_ff)
         ST_SIZE: begin
            pos_in = text_len - 1'b1;
         end
         ST_SIGN: begin
            emit        = out_free;
            rsp_char_in = CHAR_MINUS;
            rsp_last_in = 1'b0;
         end
         ST_DIGIT: begin
            emit        = out_free;
            rsp_char_in = CHAR_ZERO + {4'd0, cur_digit};
            rsp_last_in = (pos_ff == '0);
            if (out_free && pos_ff != '0) begin
               pos_in = pos_ff - 1'b1;
            end
         end
         ST_DOT: begin
            emit        = out_free;
            rsp_char_in = CHAR_DOT;
            rsp_last_in = 1'b0;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
      if (!emit) begin
         rsp_char_in = rsp_char_ff;
         rsp_last_in = rsp_last_ff;
      end
      rsp_tvalid_in = emit || (rsp_tvalid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      fmt_ff      <= fmt_in;
      pos_ff      <= pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // no new request while the converter runs
   `SVAD_ASSERT_NOW(a_busy_not_ready, conv_busy, !req_tready)
   // the last character always returns the sequencer to idle
   `SVAD_ASSERT_NEXT(a_last_to_idle, emit && rsp_last_in, state_ff == ST_IDLE)
   // text never runs past its maximum length
   `SVAD_ASSERT_NOW(a_pos_range, state_ff == ST_DIGIT, pos_ff < POS_W'(MAX_CHARS))

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for sensor_value_to_ascii_decimal_core: random and directed requests,
// a built-in formatter that predicts every character, and a checker on the rsp stream.
// Depends on svad_pkg and the RTL of the block only.

module tb_top;
   import svad_pkg::*;

   // one format request as it goes out on req_*
   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [VALUE_W-1:0] value;
      logic [MIND_W-1:0]  mind;
   } fmt_request_type;

   // one predicted character on rsp_*
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } text_char_type;

   localparam int NUM_RANDOM  = 270;
   localparam int HOLD_CYCLES = 400;   // long rsp_tready hold-off, fills the block
   localparam int DRAIN_WAIT  = 60;    // quiet time after the last expected character, for stray output

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // [32:0] value, [36:33] min_digits, [39:37] zero
   logic [2:0]  req_tuser = '0;   // [2:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] text_char
   logic        rsp_tlast;        // last_char

   fmt_request_type pending_reqs[$];
   text_char_type   expected_chars[$];
   logic [7:0]      text_buf[$];      // scratch text of the request being formatted

   int n_req_offered  = 0;
   int n_req_accepted = 0;
   int n_errors       = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;

   sensor_value_to_ascii_decimal_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial forever #5 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Formatter used for prediction
   // ---------------------------------------------------------------------------------------

   // digits of mag, zero padded to mind digits, never past the 12-character text limit
   function automatic void push_digits(longint unsigned mag, int mind);
      logic [3:0] digs[20];
      int         t;
      t = 0;
      if (mind > 20) mind = 20;
      do begin
         digs[t] = 4'(mag % 10);
         mag     = mag / 10;
         t++;
      end while (mag != 0 && t < 20);
      while (t < mind) begin
         digs[t] = 4'd0;
         t++;
      end
      while (t > 0 && text_buf.size() < MAX_CHARS) begin
         t--;
         text_buf.push_back(CHAR_ZERO + 8'(digs[t]));
      end
   endfunction

   // value in tenths: sign, integer part of at least idig digits, point, one digit
   function automatic void push_tenths(longint r, int idig);
      longint unsigned mag;
      if (r < 0) begin
         text_buf.push_back(CHAR_MINUS);
         mag = longint'(-r);
      end else begin
         mag = r;
      end
      push_digits(mag / 10, idig);
      text_buf.push_back(CHAR_DOT);
      text_buf.push_back(CHAR_ZERO + 8'(mag % 10));
   endfunction

   // expected text of one accepted request, appended to expected_chars
   function automatic void format_number(fmt_request_type rq);
      longint          v;
      longint unsigned mag;
      longint          clamped;
      longint          tenths;
      longint unsigned press;
      int              mind;
      int              neg;
      int              n;
      text_char_type   tc;
      v    = longint'($signed(rq.value));
      mag  = (v < 0) ? longint'(-v) : v;
      mind = int'(rq.mind);
      text_buf.delete();
      case (rq.mode)
         MODE_DEC: begin
            neg = (v < 0) ? 1 : 0;
            if (mind > MAX_DIGITS) mind = MAX_DIGITS;
            if (mind > MAX_CHARS - neg) mind = MAX_CHARS - neg;
            if (neg != 0) text_buf.push_back(CHAR_MINUS);
            push_digits(mag, mind);
         end
         MODE_FIX: begin
            // sign kept even when the integer part is zero
            if (v < 0) text_buf.push_back(CHAR_MINUS);
            push_digits(mag / 100, 1);
            text_buf.push_back(CHAR_DOT);
            push_digits(mag % 100, 2);
         end
         MODE_TEMP: begin
            clamped = v;
            if (clamped < -longint'(TEMP_LO_MAG)) clamped = -longint'(TEMP_LO_MAG);
            if (clamped > longint'(TEMP_HI)) clamped = longint'(TEMP_HI);
            // half away from zero; SV division truncates toward zero like C
            tenths = (clamped >= 0) ? (clamped + 5) / 10 : (clamped - 5) / 10;
            push_tenths(tenths, 1);
         end
         MODE_HUM: begin
            clamped = v;
            if (clamped < 0) clamped = 0;
            if (clamped > longint'(HUM_HI)) clamped = longint'(HUM_HI);
            tenths = (clamped + 5) / 10;
            push_tenths(tenths, (tenths / 10 >= 100) ? 3 : 2);
         end
         MODE_PRESS: begin
            // Q24.8 rounded half up, in 64 bits so it cannot wrap
            press = (longint'(rq.value[31:0]) + 128) / 256;
            push_digits(press, 5);
         end
         default: ;   // undefined mode: no text
      endcase
      n = (text_buf.size() > MAX_CHARS) ? MAX_CHARS : text_buf.size();
      for (int i = 0; i < n; i++) begin
         tc.ch   = text_buf[i];
         tc.last = (i == n - 1);
         expected_chars.push_back(tc);
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------

   function automatic void add_request(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                                       logic [MIND_W-1:0] mind);
      fmt_request_type rq;
      rq.mode  = mode;
      rq.value = value;
      rq.mind  = mind;
      pending_reqs.push_back(rq);
   endfunction

   // mix of full range, small numbers, sensor ranges, rounding edges and extremes
   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      longint             s;
      int                 kind;
      kind = $urandom_range(0, 9);
      v    = '0;
      case (kind)
         0, 1, 2, 3: begin
            v[32]   = 1'($urandom_range(0, 1));
            v[31:0] = $urandom;
         end
         4, 5: begin
            s = longint'($urandom_range(0, 400)) - 200;
            v = s[32:0];
         end
         6, 7: begin
            s = longint'($urandom_range(0, 20000)) - 7000;
            v = s[32:0];
         end
         8: begin
            // exact halves in tenths and in Q24.8
            if ($urandom_range(0, 1) == 1) begin
               s = longint'($urandom_range(0, 1800)) * 10 - 6000 + 5;
               v = s[32:0];
            end else begin
               v[31:0] = {24'($urandom_range(0, 32'hFF_FFFF)), 8'd0} |
                         32'($urandom_range(126, 130));
            end
         end
         default: begin
            case ($urandom_range(0, 4))
               0:       v = 33'h1_0000_0000;   // most negative
               1:       v = 33'h0_FFFF_FFFF;
               2:       v = 33'h1_FFFF_FFFF;   // -1
               3:       v = 33'h0_0000_0000;
               default: v = 33'h0_FFFF_FF80;   // pressure rounding at the top
            endcase
         end
      endcase
      return v;
   endfunction

   initial begin : stimulus
      int                n_valid;
      logic [MODE_W-1:0] mode;

      // directed: extremes, every mode, clamps, rounding, padding limits, undefined modes
      add_request(MODE_DEC,   33'h0_0000_0000, 4'd0);
      add_request(MODE_DEC,   33'h1_0000_0000, 4'd15);
      add_request(MODE_DEC,   33'h0_FFFF_FFFF, 4'd10);
      add_request(MODE_DEC,   33'h1_FFFF_FFFB, 4'd15);
      add_request(MODE_DEC,   33'h0_0000_0007, 4'd11);
      add_request(MODE_FIX,   33'h1_FFFF_FFFB, 4'd0);   // -0.05
      add_request(MODE_FIX,   33'h0_FFFF_FFFF, 4'd3);
      add_request(MODE_FIX,   33'h1_0000_0000, 4'd0);
      add_request(MODE_TEMP,  33'h1_FFFE_7961, 4'd0);   // -99999, clamped low
      add_request(MODE_TEMP,  33'h0_0000_2EE0, 4'd0);   // 12000
      add_request(MODE_TEMP,  33'h1_FFFF_FFF1, 4'd0);   // -15, half away from zero
      add_request(MODE_TEMP,  33'h0_0000_000F, 4'd0);
      add_request(MODE_TEMP,  33'h1_FFFF_FFFC, 4'd0);   // -4 rounds to zero
      add_request(MODE_TEMP,  33'h0_FFFF_FFFF, 4'd9);
      add_request(MODE_HUM,   33'h1_FFFF_FFFF, 4'd0);   // negative, clamped to 0
      add_request(MODE_HUM,   33'h0_0000_2710, 4'd0);   // 10000
      add_request(MODE_HUM,   33'h0_0000_270B, 4'd0);   // 9995 -> 100.0
      add_request(MODE_HUM,   33'h0_0000_0005, 4'd0);
      add_request(MODE_PRESS, 33'h0_0000_0000, 4'd0);
      add_request(MODE_PRESS, 33'h0_FFFF_FFFF, 4'd0);   // no wrap on rounding
      add_request(MODE_PRESS, 33'h1_FFFF_FF7F, 4'd0);   // top bit ignored
      add_request(MODE_PRESS, 33'h0_0000_0080, 4'd15);
      add_request(3'd5,       33'h0_0000_1234, 4'd2);
      add_request(3'd6,       33'h1_FFFF_FFFF, 4'd0);
      add_request(3'd7,       33'h0_0000_0000, 4'd15);

      // random: mostly defined modes, a few undefined ones that only get dropped
      n_valid = 0;
      while (n_valid < NUM_RANDOM) begin
         if ($urandom_range(0, 99) < 6) mode = MODE_W'($urandom_range(5, 7));
         else                           mode = MODE_W'($urandom_range(0, 4));
         add_request(mode, pick_value(), MIND_W'($urandom_range(0, 15)));
         if (mode <= MODE_PRESS) n_valid++;
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all requests taken, then all text out, then quiet time for stray characters
      while (pending_reqs.size() != 0 || n_req_offered != n_req_accepted)
         @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (n_errors == 0 && expected_chars.size() == 0) begin
         $display("sensor_value_to_ascii_decimal_core regression: pass");
      end else begin
         $display("sensor_value_to_ascii_decimal_core regression: fail");
      end
      $finish;
   end

   // hard limit, far beyond the slowest correct run
   initial begin : watchdog
      #5_000_000;
      $display("sensor_value_to_ascii_decimal_core regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Driver: req side, changes on the falling edge
   // ---------------------------------------------------------------------------------------

   // both sides run without idles while this window of requests goes through
   function automatic bit quiet_window();
      return n_req_accepted >= 100 && n_req_accepted < 160;
   endfunction

   always @(negedge clock) begin : req_driver
      fmt_request_type rq;
      bit              idle;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (n_req_offered == n_req_accepted) begin
         // nothing outstanding: offer the next request or idle
         idle = !quiet_window() && ($urandom_range(0, 99) < 15);
         if (pending_reqs.size() != 0 && !idle) begin
            rq = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {3'b000, rq.mind, rq.value};
            req_tuser  <= rq.mode;
            n_req_offered++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      // else: hold the offered request until it is taken
   end

   // rsp side: random stalls, plus one long hold-off while requests keep coming
   always @(negedge clock) begin : rsp_driver
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && n_req_accepted >= 200) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet_window() || ($urandom_range(0, 99) >= 15);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: both channels sampled on the rising edge
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin : monitor
      fmt_request_type rq;
      text_char_type   want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            rq.mode  = req_tuser;
            rq.value = req_tdata[32:0];
            rq.mind  = req_tdata[36:33];
            format_number(rq);
            n_req_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("unexpected char %h last %0b at %0t", rsp_tdata, rsp_tlast,
                           $realtime);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_tdata !== want.ch || rsp_tlast !== want.last) begin
                  n_errors++;
                  if (n_errors <= 10)
                     $display("mismatch after request %0d: expected %h last %0b, got %h last %0b",
                              n_req_accepted, want.ch, want.last, rsp_tdata, rsp_tlast);
               end
            end
         end
      end
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/svad_pkg.sv
hw/rtl/svad_prep.sv
hw/rtl/svad_dabble.sv
hw/rtl/sensor_value_to_ascii_decimal_core.sv
dv/tb_top.sv
